FILE: hdl/assert_macros.svh
// Shared assertion wrappers; every check is sampled on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is held off while reset is asserted.
`define DLAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds during reset.
`define DLAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/dlat_pkg.sv
package dlat_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned REG_IW  = 2;

  typedef enum logic [2:0] {
    OP_POLL       = 3'd0,
    OP_ARM        = 3'd1,
    OP_DISARM     = 3'd2,
    OP_DISARM_HLD = 3'd3,
    OP_REARM      = 3'd4,
    OP_CNT_RESET  = 3'd5,
    OP_FIRE_NOW   = 3'd6,
    OP_SWAP       = 3'd7
  } op_e;

  typedef enum logic [REG_IW-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_FIRE_ONCE = 2'd1,
    REG_USE_REARM = 2'd2
  } reg_e;

  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] now_time;
    logic              raw_condition;
    logic              rearm_bit;
  } item_t;

  typedef struct packed {
    logic              fired;
    logic              armed_now;
    logic              latched_now;
    logic              condition_met_now;
    logic [CNT_W-1:0]  fire_total;
    logic [CNT_W-1:0]  fire_sequence;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] debounce_time;
    logic              fire_once_mode;
    logic              use_rearm_input;
  } cfg_t;

endpackage

FILE: hdl/dlat_if.sv
interface dlat_item_if import dlat_pkg::*; ();
  logic              valid;
  logic              ready;
  op_e               op;
  logic [TIME_W-1:0] now_time;
  logic              raw_condition;
  logic              rearm_bit;

  modport source (output valid, output op, output now_time, output raw_condition,
                  output rearm_bit, input ready);
  modport sink   (input valid, input op, input now_time, input raw_condition,
                  input rearm_bit, output ready);
endinterface

interface dlat_result_if import dlat_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             fired;
  logic             armed_now;
  logic             latched_now;
  logic             condition_met_now;
  logic [CNT_W-1:0] fire_total;
  logic [CNT_W-1:0] fire_sequence;

  modport source (output valid, output fired, output armed_now, output latched_now,
                  output condition_met_now, output fire_total, output fire_sequence,
                  input ready);
  modport sink   (input valid, input fired, input armed_now, input latched_now,
                  input condition_met_now, input fire_total, input fire_sequence,
                  output ready);
endinterface

FILE: hdl/dlat_cfg_regs.sv
module dlat_cfg_regs import dlat_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t              cfg_q, cfg_d;
  logic              wr_en;
  logic [REG_IW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[REG_IW+1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DEBOUNCE:  cfg_d.debounce_time   = pwdata[TIME_W-1:0];
        REG_FIRE_ONCE: cfg_d.fire_once_mode  = pwdata[0];
        REG_USE_REARM: cfg_d.use_rearm_input = pwdata[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE:  prdata = cfg_q.debounce_time;
      REG_FIRE_ONCE: prdata = {{(APB_DW-1){1'b0}}, cfg_q.fire_once_mode};
      REG_USE_REARM: prdata = {{(APB_DW-1){1'b0}}, cfg_q.use_rearm_input};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/dlat_core.sv
module dlat_core import dlat_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t res_o
);

`include "assert_macros.svh"

  logic              armed_q, armed_d;
  logic              latched_q, latched_d;
  logic              edge_rdy_q, edge_rdy_d;
  logic              met_q, met_d;
  logic              raw_held_q, raw_held_d;
  logic [TIME_W-1:0] raw_start_q, raw_start_d;
  logic              polled_q, polled_d;
  logic [TIME_W-1:0] last_poll_q, last_poll_d;
  logic [CNT_W-1:0]  fire_cnt_q, fire_cnt_d;
  logic [CNT_W-1:0]  fire_seq_q, fire_seq_d;
  logic [TIME_W-1:0] held_for;
  logic              fire;
  logic              clr_track;

  always_comb begin
    armed_d     = armed_q;
    latched_d   = latched_q;
    edge_rdy_d  = edge_rdy_q;
    met_d       = met_q;
    raw_held_d  = raw_held_q;
    raw_start_d = raw_start_q;
    polled_d    = polled_q;
    last_poll_d = last_poll_q;
    fire_cnt_d  = fire_cnt_q;
    fire_seq_d  = fire_seq_q;
    held_for    = '0;
    fire        = 1'b0;
    clr_track   = 1'b0;

    unique case (item_i.op)
      OP_POLL: begin
        // drop polls while disarmed or on a repeated timestamp
        if (armed_q && !(polled_q && item_i.now_time == last_poll_q)) begin
          polled_d    = 1'b1;
          last_poll_d = item_i.now_time;
          if (item_i.raw_condition) begin
            if (!raw_held_q) begin
              raw_held_d  = 1'b1;
              raw_start_d = item_i.now_time;
            end
            held_for = item_i.now_time - raw_start_d;
            met_d    = held_for >= cfg_i.debounce_time;
          end else begin
            raw_held_d  = 1'b0;
            raw_start_d = '0;
            met_d       = 1'b0;
          end
          if (latched_q) begin
            if (cfg_i.use_rearm_input) begin
              if (item_i.rearm_bit) latched_d = 1'b0;
            end else if (!met_d) begin
              latched_d = 1'b0;
            end
          end
          if (!latched_d && !met_d) edge_rdy_d = 1'b1;
          fire = met_d && edge_rdy_d && !latched_d;
        end
      end
      OP_ARM: begin
        latched_d  = 1'b0;
        edge_rdy_d = 1'b1;
        clr_track  = 1'b1;
        armed_d    = 1'b1;
      end
      OP_DISARM: begin
        armed_d = 1'b0;
      end
      OP_DISARM_HLD: begin
        latched_d  = 1'b1;
        edge_rdy_d = 1'b0;
      end
      OP_REARM: begin
        latched_d = 1'b0;
      end
      OP_CNT_RESET: begin
        latched_d  = 1'b0;
        fire_cnt_d = '0;
        clr_track  = 1'b1;
      end
      OP_FIRE_NOW: begin
        fire = 1'b1;
      end
      OP_SWAP: begin
        clr_track = 1'b1;
      end
      default: begin
        clr_track = 1'b0;
      end
    endcase

    if (clr_track) begin
      met_d       = 1'b0;
      raw_held_d  = 1'b0;
      raw_start_d = '0;
      polled_d    = 1'b0;
      last_poll_d = '0;
    end

    if (fire) begin
      latched_d  = 1'b1;
      edge_rdy_d = 1'b0;
      fire_cnt_d = fire_cnt_d + 1'b1;
      fire_seq_d = fire_seq_q + 1'b1;
      if (cfg_i.fire_once_mode) armed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      latched_q   <= 1'b0;
      edge_rdy_q  <= 1'b0;
      met_q       <= 1'b0;
      raw_held_q  <= 1'b0;
      raw_start_q <= '0;
      polled_q    <= 1'b0;
      last_poll_q <= '0;
      fire_cnt_q  <= '0;
      fire_seq_q  <= '0;
    end else if (step_i) begin
      armed_q     <= armed_d;
      latched_q   <= latched_d;
      edge_rdy_q  <= edge_rdy_d;
      met_q       <= met_d;
      raw_held_q  <= raw_held_d;
      raw_start_q <= raw_start_d;
      polled_q    <= polled_d;
      last_poll_q <= last_poll_d;
      fire_cnt_q  <= fire_cnt_d;
      fire_seq_q  <= fire_seq_d;
    end
  end

  assign res_o.fired             = fire;
  assign res_o.armed_now         = armed_d;
  assign res_o.latched_now       = latched_d;
  assign res_o.condition_met_now = met_d;
  assign res_o.fire_total        = fire_cnt_d;
  assign res_o.fire_sequence     = fire_seq_d;

  `DLAT_ASSERT(a_fire_sets_latch, step_i && fire |=> latched_q && !edge_rdy_q, "fire left latch open")
  `DLAT_ASSERT(a_seq_bump, step_i && fire |=> fire_seq_q == $past(fire_seq_q) + 1'b1, "serial not bumped")
  `DLAT_ASSERT(a_idle_poll, step_i && item_i.op == OP_POLL && !armed_q |=> $stable(last_poll_q) && $stable(met_q), "disarmed poll changed tracking")

endmodule

FILE: hdl/debounced_latched_auto_trigger.sv
// Channel    | Dir | Beat contents
// item_i     | in  | op, now_time, raw_condition, rearm_bit
// result_o   | out | fired, armed_now, latched_now, condition_met_now, fire_total, fire_sequence
// APB        | in  | debounce_time, fire_once_mode, use_rearm_input at 0x0, 0x4, 0x8
//
// One item per cycle while result_o is not stalled. A beat lands in the input register;
// the state update is one combinational pass, and the result register takes it once
// result_o has room, so the result is offered from that register after its beat is taken.
// Reset clears all trigger state and both counters at once; no clearing pass.
// While result_o is stalled one more item waits in the input register.
module debounced_latched_auto_trigger import dlat_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  dlat_item_if.sink         item_i,
  dlat_result_if.source     result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

`include "assert_macros.svh"

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q;
  result_t res, res_q;
  logic    out_vld_q;
  logic    out_free;
  logic    advance;

  dlat_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_free     = !out_vld_q || result_o.ready;
  assign advance      = in_vld_q && out_free;
  assign item_i.ready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (item_i.ready) begin
      in_vld_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      item_q.op            <= item_i.op;
      item_q.now_time      <= item_i.now_time;
      item_q.raw_condition <= item_i.raw_condition;
      item_q.rearm_bit     <= item_i.rearm_bit;
    end
  end

  dlat_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .item_i (item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res;
  end

  assign result_o.valid             = out_vld_q;
  assign result_o.fired             = res_q.fired;
  assign result_o.armed_now         = res_q.armed_now;
  assign result_o.latched_now       = res_q.latched_now;
  assign result_o.condition_met_now = res_q.condition_met_now;
  assign result_o.fire_total        = res_q.fire_total;
  assign result_o.fire_sequence     = res_q.fire_sequence;

  `DLAT_ASSERT(a_in_hold, in_vld_q && !out_free |=> in_vld_q && $stable(item_q), "queued item lost under stall")
  `DLAT_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule
